// ===== rtl/wad_pkg.sv =====
// Package for the four-channel window alarm with integrating debounce.
// Holds sizes, register indexes and the per-channel status type; no dependencies.
package wad_pkg;

  localparam int CHANNELS      = 4;
  localparam int SAMPLE_BITS   = 10;
  localparam int ALARM_DELAY   = 30;
  localparam int STARTUP_TICKS = 30;
  localparam int MIDPOINT      = ALARM_DELAY / 2;

  localparam int CNT_W   = $clog2(ALARM_DELAY + 1);
  localparam int START_W = $clog2(STARTUP_TICKS + 1);
  localparam int THR_W   = 16;
  localparam int LIM_W   = 2 * THR_W;
  localparam int ACK_CH_W  = 2;
  localparam int ACK_VAL_W = 8;

  // input word layout
  localparam int ACK_CH_LSB  = CHANNELS * SAMPLE_BITS;
  localparam int ACK_VAL_LSB = ACK_CH_LSB + ACK_CH_W;
  localparam int IN_BITS     = ACK_VAL_LSB + ACK_VAL_W;
  localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W  = 16;

  localparam logic [LIM_W-1:0] LIMITS_RESET = 32'h03FF_0000;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMITS_CH0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMITS_CH1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMITS_CH2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMITS_CH3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FOLLOW     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NOTIFY     = 3'd5;

  // word kind
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ACK  = 1'b1;

  localparam logic [ACK_VAL_W-1:0] BYTE_SET   = 8'hFF;
  localparam logic [ACK_VAL_W-1:0] BYTE_CLEAR = 8'h00;

  typedef struct packed {
    logic alarm;
    logic follower;
  } chan_stat_t;

endpackage

// ===== rtl/window_alarm_integrating_debounce.sv =====
// Top level of the four-channel window alarm with integrating debounce.
// Depends on wad_pkg and wad_chan.
//
// Takes one word per clock while out_tready is high and returns one result
// word per input word. State is updated at the edge a word is accepted and the
// result is loaded into an output register, so it is valid in the cycle after
// the word is accepted; in_tready drops only while a result is held unread.
// Ticks are ignored for the first STARTUP_TICKS - 1 ticks after reset; the tick
// that empties the start-up counter already compares. Configuration writes are
// always accepted and should be made while the block is idle.
module window_alarm_integrating_debounce import wad_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [9:0] sample_a, [19:10] sample_b, [29:20] sample_c, [39:30] sample_d,
  // [41:40] ack_channel, [49:42] ack_value, rest zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] op
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [3:0] alarm_flags, [7:4] follower_bits, [11:8] notify_pending, rest zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [LIM_W-1:0]      cfg_data
);

  logic [LIM_W-1:0]     limits_r [CHANNELS];
  logic [CHANNELS-1:0]  follow_mask_r, notify_mask_r;
  logic [START_W-1:0]   startup_r, startup_nxt;
  logic [ACK_VAL_W-1:0] acked_r [CHANNELS];
  logic [ACK_VAL_W-1:0] acked_nxt [CHANNELS];
  logic                 out_valid_r;
  logic [CHANNELS-1:0]  flags_r, foll_r, notif_r;
  logic [CHANNELS-1:0]  flags_nxt, foll_nxt, notif_nxt;
  logic                 in_acc, tick, run;
  logic [ACK_CH_W-1:0]  ack_ch;
  logic [ACK_VAL_W-1:0] ack_val;
  chan_stat_t           stat [CHANNELS];

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign tick      = in_acc && (in_tuser == OP_TICK);
  assign ack_ch    = in_tdata[ACK_CH_LSB +: ACK_CH_W];
  assign ack_val   = in_tdata[ACK_VAL_LSB +: ACK_VAL_W];
  assign cfg_ready = 1'b1;

  always_comb begin
    startup_nxt = startup_r;
    if (tick && startup_r != '0) startup_nxt = startup_r - 1'b1;
  end
  assign run = tick && (startup_nxt == '0);

  for (genvar i = 0; i < CHANNELS; i++) begin : g_ch
    wad_chan u_chan (
      .clk      (clk),
      .rst_n    (rst_n),
      .run      (run),
      .sample   (in_tdata[i*SAMPLE_BITS +: SAMPLE_BITS]),
      .limits   (limits_r[i]),
      .follow   (follow_mask_r[i]),
      .stat_nxt (stat[i])
    );

    always_comb begin
      acked_nxt[i] = acked_r[i];
      if (in_acc && in_tuser == OP_ACK && int'(ack_ch) == i) acked_nxt[i] = ack_val;
      flags_nxt[i] = stat[i].alarm;
      foll_nxt[i]  = stat[i].follower;
      notif_nxt[i] = notify_mask_r[i] &&
                     ((stat[i].alarm ? BYTE_SET : BYTE_CLEAR) != acked_nxt[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      startup_r   <= START_W'(STARTUP_TICKS);
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) acked_r[i] <= '0;
    end else begin
      startup_r <= startup_nxt;
      for (int i = 0; i < CHANNELS; i++) acked_r[i] <= acked_nxt[i];
      if (in_acc) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      flags_r <= flags_nxt;
      foll_r  <= foll_nxt;
      notif_r <= notif_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) limits_r[i] <= LIMITS_RESET;
      follow_mask_r <= '0;
      notify_mask_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LIMITS_CH0, REG_LIMITS_CH1, REG_LIMITS_CH2, REG_LIMITS_CH3: begin
          limits_r[cfg_index[ACK_CH_W-1:0]] <= cfg_data;
        end
        REG_FOLLOW: follow_mask_r <= cfg_data[CHANNELS-1:0];
        REG_NOTIFY: notify_mask_r <= cfg_data[CHANNELS-1:0];
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({notif_r, foll_r, flags_r});

`ifndef SYNTH
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_tvalid)
    else $error("accepted word produced no result");

  a_ready_only_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_valid_r)
    else $error("input stalled with no result held");

  a_quiet_startup: assert property (@(posedge clk) disable iff (!rst_n)
    (startup_r != '0 && out_valid_r) |-> (flags_r == '0 && foll_r == '0))
    else $error("alarm raised during start-up");
`endif

endmodule

// ===== rtl/wad_chan.sv =====
// One channel: window compare, integrating debounce counter, alarm and follower.
// Depends on wad_pkg.
module wad_chan import wad_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   run,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [LIM_W-1:0]       limits,
  input  logic                   follow,
  output chan_stat_t             stat_nxt
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             alarm_r, alarm_nxt;
  logic             follower_r, follower_nxt;
  logic [THR_W-1:0] samp_ext;
  logic             above, below;

  assign samp_ext = THR_W'(sample);
  assign above    = samp_ext > limits[LIM_W-1:THR_W];
  assign below    = samp_ext < limits[THR_W-1:0];

  always_comb begin
    cnt_nxt      = cnt_r;
    alarm_nxt    = alarm_r;
    follower_nxt = follower_r;
    if (run) begin
      if (above) begin
        if (cnt_r < CNT_W'(ALARM_DELAY)) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_nxt == CNT_W'(ALARM_DELAY)) begin
            alarm_nxt = 1'b1;
            if (follow) follower_nxt = 1'b1;
          end
        end
      end else if (below) begin
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_nxt == '0) begin
            alarm_nxt = 1'b0;
            if (follow) follower_nxt = 1'b0;
          end
        end
      end else begin
        cnt_nxt = CNT_W'(MIDPOINT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= CNT_W'(MIDPOINT);
      alarm_r    <= 1'b0;
      follower_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      alarm_r    <= alarm_nxt;
      follower_r <= follower_nxt;
    end
  end

  assign stat_nxt.alarm    = alarm_nxt;
  assign stat_nxt.follower = follower_nxt;

endmodule

// ===== test/wad_status_checker.sv =====
`timescale 1ns / 1ps
// Status checker for window_alarm_integrating_debounce: watches the input, result and
// register write channels, predicts each status word and compares it field by field.
// Depends on wad_pkg.
module wad_status_checker import wad_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [LIM_W-1:0]      cfg_data,
  output int                    errors,
  output int                    outstanding
);

  localparam int FLAG_LSB = 0;
  localparam int FOLL_LSB = 4;
  localparam int PEND_LSB = 8;

  logic [LIM_W-1:0]      lim_q [CHANNELS];
  logic [CHANNELS-1:0]   follow_en;
  logic [CHANNELS-1:0]   notify_en;
  logic [START_W-1:0]    boot_cnt;
  logic [CNT_W-1:0]      deb_cnt [CHANNELS];
  logic [CHANNELS-1:0]   alarm_q;
  logic [CHANNELS-1:0]   follower_q;
  logic [ACK_VAL_W-1:0]  acked_q [CHANNELS];
  logic [OUT_DATA_W-1:0] status_due_q [$];

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  task automatic predict_status(input logic op, input logic [IN_DATA_W-1:0] d,
                                output logic [OUT_DATA_W-1:0] st);
    logic [SAMPLE_BITS-1:0] smp;
    logic [THR_W-1:0]       hi;
    logic [THR_W-1:0]       lo;
    logic [ACK_CH_W-1:0]    ach;
    logic [CHANNELS-1:0]    pend;
    pend = '0;
    st   = '0;
    if (op == OP_TICK) begin
      if (boot_cnt != 0) boot_cnt = boot_cnt - 1'b1;
      if (boot_cnt == 0) begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
          smp = d[ch*SAMPLE_BITS +: SAMPLE_BITS];
          hi  = lim_q[ch][LIM_W-1:THR_W];
          lo  = lim_q[ch][THR_W-1:0];
          if (smp > hi) begin
            if (deb_cnt[ch] < ALARM_DELAY) begin
              deb_cnt[ch] = deb_cnt[ch] + 1'b1;
              if (deb_cnt[ch] == ALARM_DELAY) begin
                alarm_q[ch] = 1'b1;
                if (follow_en[ch]) follower_q[ch] = 1'b1;
              end
            end
          end else if (smp < lo) begin
            if (deb_cnt[ch] > 0) begin
              deb_cnt[ch] = deb_cnt[ch] - 1'b1;
              if (deb_cnt[ch] == 0) begin
                alarm_q[ch] = 1'b0;
                if (follow_en[ch]) follower_q[ch] = 1'b0;
              end
            end
          end else begin
            deb_cnt[ch] = CNT_W'(MIDPOINT);
          end
        end
      end
    end else begin
      ach = d[ACK_CH_LSB +: ACK_CH_W];
      if (ach < CHANNELS) acked_q[ach] = d[ACK_VAL_LSB +: ACK_VAL_W];
    end
    for (int ch = 0; ch < CHANNELS; ch++)
      pend[ch] = notify_en[ch] && ((alarm_q[ch] ? BYTE_SET : BYTE_CLEAR) != acked_q[ch]);
    st[FLAG_LSB +: CHANNELS] = alarm_q;
    st[FOLL_LSB +: CHANNELS] = follower_q;
    st[PEND_LSB +: CHANNELS] = pend;
  endtask

  task automatic check_status(input logic [OUT_DATA_W-1:0] got);
    logic [OUT_DATA_W-1:0] want;
    if (status_due_q.size() == 0) begin
      errors++;
      $display("%0t: status word %h arrived with none expected", $time, got);
      return;
    end
    want = status_due_q.pop_front();
    if (got[FLAG_LSB +: CHANNELS] != want[FLAG_LSB +: CHANNELS]) begin
      errors++;
      $display("%0t: alarm_flags expected %h got %h", $time,
               want[FLAG_LSB +: CHANNELS], got[FLAG_LSB +: CHANNELS]);
    end
    if (got[FOLL_LSB +: CHANNELS] != want[FOLL_LSB +: CHANNELS]) begin
      errors++;
      $display("%0t: follower_bits expected %h got %h", $time,
               want[FOLL_LSB +: CHANNELS], got[FOLL_LSB +: CHANNELS]);
    end
    if (got[PEND_LSB +: CHANNELS] != want[PEND_LSB +: CHANNELS]) begin
      errors++;
      $display("%0t: notify_pending expected %h got %h", $time,
               want[PEND_LSB +: CHANNELS], got[PEND_LSB +: CHANNELS]);
    end
  endtask

  always @(posedge clk) begin
    logic [OUT_DATA_W-1:0] st;
    if (!rst_n) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        lim_q[ch]   = LIMITS_RESET;
        deb_cnt[ch] = CNT_W'(MIDPOINT);
        acked_q[ch] = BYTE_CLEAR;
      end
      follow_en  = '0;
      notify_en  = '0;
      boot_cnt   = START_W'(STARTUP_TICKS);
      alarm_q    = '0;
      follower_q = '0;
      status_due_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LIMITS_CH0, REG_LIMITS_CH1, REG_LIMITS_CH2, REG_LIMITS_CH3:
            lim_q[cfg_index[ACK_CH_W-1:0]] = cfg_data;
          REG_FOLLOW: follow_en = cfg_data[CHANNELS-1:0];
          REG_NOTIFY: notify_en = cfg_data[CHANNELS-1:0];
          default: ;
        endcase
      end
      // result leaves after its word is accepted, so retire before predicting
      if (out_tvalid && out_tready) check_status(out_tdata);
      if (in_tvalid && in_tready) begin
        predict_status(in_tuser, in_tdata, st);
        status_due_q.push_back(st);
      end
    end
    outstanding = status_due_q.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for window_alarm_integrating_debounce: drives register writes and
// words with random idling, and gives the verdict. Depends on wad_pkg, the block
// and wad_status_checker.
module tb import wad_pkg::*; ();

  localparam int STALL_LIMIT = 2000;
  localparam int SMP_MAX     = (1 << SAMPLE_BITS) - 1;

  typedef enum int {TREND_ABOVE, TREND_BELOW, TREND_INSIDE, TREND_ANY} trend_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = OP_TICK;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [LIM_W-1:0]      cfg_data   = '0;

  int errors;
  int outstanding;
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int quiet_cycles  = 0;
  logic [LIM_W-1:0] lim_set [CHANNELS];

  window_alarm_integrating_debounce u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  wad_status_checker u_status_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99, 0) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_word(
    input logic [SAMPLE_BITS-1:0] s0, s1, s2, s3,
    input logic [ACK_CH_W-1:0] ach, input logic [ACK_VAL_W-1:0] aval);
    logic [IN_DATA_W-1:0] w;
    w = '0;
    w[0*SAMPLE_BITS +: SAMPLE_BITS] = s0;
    w[1*SAMPLE_BITS +: SAMPLE_BITS] = s1;
    w[2*SAMPLE_BITS +: SAMPLE_BITS] = s2;
    w[3*SAMPLE_BITS +: SAMPLE_BITS] = s3;
    w[ACK_CH_LSB +: ACK_CH_W]       = ach;
    w[ACK_VAL_LSB +: ACK_VAL_W]     = aval;
    return w;
  endfunction

  // sample in the requested region of the window, any sample if it is empty
  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input trend_t trend,
                                                          input logic [LIM_W-1:0] lim);
    int hi;
    int lo;
    hi = lim[LIM_W-1:THR_W];
    lo = lim[THR_W-1:0];
    case (trend)
      TREND_ABOVE:  if (hi < SMP_MAX)
                      return SAMPLE_BITS'($urandom_range(SMP_MAX, hi + 1));
      TREND_BELOW:  if (lo > 0)
                      return SAMPLE_BITS'($urandom_range((lo > SMP_MAX) ? SMP_MAX : lo - 1,
                                                         0));
      TREND_INSIDE: if (lo <= hi && lo <= SMP_MAX)
                      return SAMPLE_BITS'($urandom_range((hi > SMP_MAX) ? SMP_MAX : hi, lo));
      default: ;
    endcase
    return SAMPLE_BITS'($urandom_range(SMP_MAX, 0));
  endfunction

  // entered and left at a falling edge; valid stays up for a back-to-back word
  task automatic send_word(input logic op, input logic [IN_DATA_W-1:0] d);
    if ($urandom_range(99, 0) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99, 0) < src_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_settings(input int ph);
    logic [CHANNELS-1:0] fol;
    logic [CHANNELS-1:0] ntf;
    logic [THR_W-1:0]    hi;
    logic [THR_W-1:0]    lo;
    case (ph)
      0: begin
        lim_set[0] = {16'd700, 16'd300};
        lim_set[1] = {16'hFFFF, 16'h0000};  // never leaves the window
        lim_set[2] = {16'h0000, 16'hFFFF};  // only zero reads below
        lim_set[3] = {16'd1022, 16'd1};
        fol = '1;
        ntf = '1;
      end
      1: begin
        for (int ch = 0; ch < CHANNELS - 1; ch++) begin
          hi = THR_W'($urandom_range(SMP_MAX, 200));
          lo = THR_W'($urandom_range(hi, 0));
          lim_set[ch] = {hi, lo};
        end
        lim_set[CHANNELS-1] = LIMITS_RESET;
        fol = '0;
        ntf = '0;
      end
      default: begin
        lim_set[0] = '1;
        lim_set[1] = '0;
        lo = THR_W'($urandom_range(1000, 0));
        hi = THR_W'(lo + $urandom_range(20, 0));
        lim_set[2] = {hi, lo};
        lim_set[3] = {16'd512, 16'd511};
        fol = 4'h6;
        ntf = 4'h9;
      end
    endcase
    write_reg(REG_LIMITS_CH0, lim_set[0]);
    write_reg(REG_LIMITS_CH1, lim_set[1]);
    write_reg(REG_LIMITS_CH2, lim_set[2]);
    write_reg(REG_LIMITS_CH3, lim_set[3]);
    write_reg(REG_FOLLOW, LIM_W'(fol));
    write_reg(REG_NOTIFY, LIM_W'(ntf));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    logic [SAMPLE_BITS-1:0] s;
    // acks during start-up, full-scale sample fields ignored
    send_word(OP_ACK, pack_word('1, '1, '1, '1, 2'd0, BYTE_SET));
    send_word(OP_ACK, pack_word('0, '0, '0, '0, 2'd3, 8'hA5));
    // start-up ticks with extreme samples; only the last one compares
    for (int i = 0; i < STARTUP_TICKS; i++) begin
      s = i[0] ? SAMPLE_BITS'(SMP_MAX) : '0;
      send_word(OP_TICK, pack_word(s, s, s, s, i[0] ? 2'd3 : 2'd0,
                                   i[0] ? BYTE_SET : BYTE_CLEAR));
    end
    // samples on the channel 0 and 3 thresholds sit inside the window
    send_word(OP_TICK, pack_word(10'd700, 10'd0, 10'd0, 10'd1022, 2'd2, 8'h5A));
    send_word(OP_TICK, pack_word(10'd300, 10'd1023, 10'd1023, 10'd1, 2'd1, 8'hC3));
    send_word(OP_ACK, pack_word(10'd1023, 10'd0, 10'd1023, 10'd0, 2'd1, BYTE_SET));
    send_word(OP_ACK, pack_word(10'd0, 10'd1023, 10'd0, 10'd1023, 2'd2, BYTE_CLEAR));
    send_word(OP_TICK, pack_word(10'd701, 10'd299, 10'd1, 10'd0, 2'd3, 8'hFF));
    send_word(OP_TICK, pack_word(10'd299, 10'd701, 10'd0, 10'd1023, 2'd0, 8'h00));
  endtask

  // runs of ticks pushing each channel one way, with acks and noise mixed in
  task automatic run_random(input int n_words);
    trend_t                 trend [CHANNELS];
    logic [SAMPLE_BITS-1:0] smp [CHANNELS];
    logic [ACK_VAL_W-1:0]   aval;
    int                     done;
    int                     run_len;
    int                     r;
    done = 0;
    while (done < n_words) begin
      run_len = $urandom_range(40, 1);
      foreach (trend[ch]) trend[ch] = trend_t'($urandom_range(3, 0));
      for (int k = 0; k < run_len && done < n_words; k++) begin
        r = $urandom_range(99, 0);
        foreach (smp[ch])
          smp[ch] = (r < 20) ? SAMPLE_BITS'($urandom_range(SMP_MAX, 0)) :
                               pick_sample(trend[ch], lim_set[ch]);
        case ($urandom_range(2, 0))
          0:       aval = BYTE_SET;
          1:       aval = BYTE_CLEAR;
          default: aval = ACK_VAL_W'($urandom);
        endcase
        send_word((r < 12) ? OP_ACK : OP_TICK,
                  pack_word(smp[0], smp[1], smp[2], smp[3],
                            ACK_CH_W'($urandom_range(3, 0)), aval));
        done++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       begin src_idle_pct = 31; sink_idle_pct = 61; end
        1:       begin src_idle_pct = 61; sink_idle_pct = 31; end
        default: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
      endcase
      apply_settings(ph);
      if (ph == 0) run_directed();
      run_random(150);
      in_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clk);
      repeat (2) @(negedge clk);
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/wad_pkg.sv
rtl/wad_chan.sv
rtl/window_alarm_integrating_debounce.sv
test/wad_status_checker.sv
test/tb.sv
